>>> rtl/core/tstt_pkg.sv
`timescale 1ns / 1ps

package tstt_pkg;

  // Field widths
  localparam int OP_W  = 4;
  localparam int ID_W  = 8;
  localparam int CNT_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK       = 4'd0;
  localparam logic [OP_W-1:0] OP_START      = 4'd1;
  localparam logic [OP_W-1:0] OP_STOP       = 4'd2;
  localparam logic [OP_W-1:0] OP_RESTART    = 4'd3;
  localparam logic [OP_W-1:0] OP_READ_CLEAR = 4'd4;
  localparam logic [OP_W-1:0] OP_PEEK       = 4'd5;
  localparam logic [OP_W-1:0] OP_QUERY      = 4'd6;
  localparam logic [OP_W-1:0] OP_FORCE      = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

  // Prescalers (ms per tier unit)
  localparam int TENTH_PRE_W   = 7;
  localparam int SEC_PRE_W     = 10;
  localparam int MS_PER_TENTH  = 100;
  localparam int MS_PER_SECOND = 1000;

  // Tier codes
  localparam logic [1:0] TIER_FAST = 2'd0;
  localparam logic [1:0] TIER_MID  = 2'd1;
  localparam logic [1:0] TIER_SLOW = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic latch;     // capture incoming word
    logic exec;      // run a table operation / advance counters on tick
    logic scan_rd;   // issue a scan read at the scan index
    logic out_load;  // move response into the output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic op_tick;   // captured word is a tick
    logic scan_last; // scan index is at the last entry
  } sts_t;

endpackage

>>> rtl/core/tstt_ctrl.sv
`timescale 1ns / 1ps

module tstt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  tstt_pkg::sts_t sts_i,
  output tstt_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.op_tick ? ST_SCAN : ST_RESP;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last entry is evaluated here
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/tstt_dp.sv
`timescale 1ns / 1ps

module tstt_dp #(
  parameter int NUM_TIMERS = 32,
  parameter int FAST_END   = 16,
  parameter int MID_END    = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tstt_pkg::cmd_t              cmd_i,
  output tstt_pkg::sts_t              sts_o,
  input  logic [tstt_pkg::OP_W-1:0]   operation_i,
  input  logic [tstt_pkg::ID_W-1:0]   timer_id_i,
  input  logic [tstt_pkg::CNT_W-1:0]  period_i,
  output logic                        accepted_o,
  output logic                        flag_value_o
);

  localparam int IDX_W = $clog2(NUM_TIMERS);
  localparam int CW    = tstt_pkg::CNT_W;

  // Captured word
  logic [tstt_pkg::OP_W-1:0] op_q;
  logic [tstt_pkg::ID_W-1:0] id_q;
  logic [CW-1:0]             per_q;

  // Tier counters and prescalers
  logic [CW-1:0]                    ms_q, tenth_q, sec_q;
  logic [tstt_pkg::TENTH_PRE_W-1:0] pre100_q;
  logic [tstt_pkg::SEC_PRE_W-1:0]   pre1000_q;
  logic                             tenth_adv_q, sec_adv_q;
  logic                             tenth_wrap, sec_wrap;

  // Table state
  logic [NUM_TIMERS-1:0] running_q, expired_q;
  logic [CW-1:0]         period_mem [NUM_TIMERS];
  logic [CW-1:0]         origin_mem [NUM_TIMERS];

  // Scan pipeline
  logic [IDX_W-1:0] rd_idx_q, eval_idx_q;
  logic             eval_v_q;
  logic [CW-1:0]    rd_period_q, rd_origin_q;

  logic             resp_acc_q, resp_flag_q, resp_acc_d, resp_flag_d;
  logic             acc_q, flag_q;

  logic             in_range, op_known, op_do;
  logic [IDX_W-1:0] op_idx;
  logic [CW-1:0]    op_now;
  logic [1:0]       eval_tier;
  logic             eval_en, hit;
  logic [CW-1:0]    eval_now, elapsed;
  logic             origin_we, period_we;
  logic [IDX_W-1:0] origin_wa;
  logic [CW-1:0]    origin_wd;

  function automatic logic [1:0] tier_of(input logic [tstt_pkg::ID_W-1:0] id);
    logic [1:0] t;
    if (id < tstt_pkg::ID_W'(FAST_END)) t = tstt_pkg::TIER_FAST;
    else if (id < tstt_pkg::ID_W'(MID_END)) t = tstt_pkg::TIER_MID;
    else t = tstt_pkg::TIER_SLOW;
    return t;
  endfunction

  function automatic logic [CW-1:0] tier_cnt(input logic [1:0] tier,
                                              input logic [CW-1:0] ms,
                                              input logic [CW-1:0] tenth,
                                              input logic [CW-1:0] sec);
    logic [CW-1:0] c;
    if (tier == tstt_pkg::TIER_FAST) c = ms;
    else if (tier == tstt_pkg::TIER_MID) c = tenth;
    else c = sec;
    return c;
  endfunction

  assign sts_o.op_tick   = (op_q == tstt_pkg::OP_TICK);
  assign sts_o.scan_last = (rd_idx_q == IDX_W'(NUM_TIMERS - 1));

  assign in_range = (id_q < tstt_pkg::ID_W'(NUM_TIMERS));
  assign op_known = (op_q >= tstt_pkg::OP_START) && (op_q <= tstt_pkg::OP_CLEAR);
  assign op_do    = cmd_i.exec && in_range && op_known;
  assign op_idx   = id_q[IDX_W-1:0];
  assign op_now   = tier_cnt(tier_of(id_q), ms_q, tenth_q, sec_q);

  assign tenth_wrap = (pre100_q == tstt_pkg::TENTH_PRE_W'(tstt_pkg::MS_PER_TENTH - 1));
  assign sec_wrap   = (pre1000_q == tstt_pkg::SEC_PRE_W'(tstt_pkg::MS_PER_SECOND - 1));

  // Scan evaluation: one entry per cycle, one behind the read
  assign eval_tier = tier_of(tstt_pkg::ID_W'(eval_idx_q));
  assign eval_now  = tier_cnt(eval_tier, ms_q, tenth_q, sec_q);
  assign elapsed   = eval_now - rd_origin_q;
  assign eval_en   = eval_v_q && running_q[eval_idx_q] &&
                     ((eval_tier == tstt_pkg::TIER_FAST) ||
                      ((eval_tier == tstt_pkg::TIER_MID) && tenth_adv_q) ||
                      ((eval_tier == tstt_pkg::TIER_SLOW) && sec_adv_q));
  assign hit       = eval_en && (elapsed >= rd_period_q);

  assign period_we = op_do && (op_q == tstt_pkg::OP_START);
  assign origin_we = hit || (op_do && ((op_q == tstt_pkg::OP_START) ||
                                       (op_q == tstt_pkg::OP_RESTART)));
  assign origin_wa = hit ? eval_idx_q : op_idx;
  assign origin_wd = hit ? eval_now : op_now;

  always_comb begin
    resp_acc_d  = 1'b0;
    resp_flag_d = 1'b0;
    if (op_q == tstt_pkg::OP_TICK) begin
      resp_acc_d = 1'b1;
    end else if (in_range && op_known) begin
      resp_acc_d = 1'b1;
      case (op_q)
        tstt_pkg::OP_READ_CLEAR, tstt_pkg::OP_PEEK: resp_flag_d = expired_q[op_idx];
        tstt_pkg::OP_QUERY:                         resp_flag_d = running_q[op_idx];
        default:                                    resp_flag_d = 1'b0;
      endcase
    end
  end

  // Payload capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= operation_i;
      id_q  <= timer_id_i;
      per_q <= period_i;
    end
    if (cmd_i.exec) begin
      resp_acc_q  <= resp_acc_d;
      resp_flag_q <= resp_flag_d;
    end
    if (cmd_i.out_load) begin
      acc_q  <= resp_acc_q;
      flag_q <= resp_flag_q;
    end
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (period_we) begin
      period_mem[op_idx] <= per_q;
    end
    if (origin_we) begin
      origin_mem[origin_wa] <= origin_wd;
    end
    if (cmd_i.scan_rd) begin
      rd_period_q <= period_mem[rd_idx_q];
      rd_origin_q <= origin_mem[rd_idx_q];
    end
  end

  // Counters, flags and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q        <= '0;
      tenth_q     <= '0;
      sec_q       <= '0;
      pre100_q    <= '0;
      pre1000_q   <= '0;
      tenth_adv_q <= 1'b0;
      sec_adv_q   <= 1'b0;
      running_q   <= '0;
      expired_q   <= '0;
      rd_idx_q    <= '0;
      eval_idx_q  <= '0;
      eval_v_q    <= 1'b0;
    end else begin
      eval_v_q   <= cmd_i.scan_rd;
      eval_idx_q <= rd_idx_q;
      if (cmd_i.latch) begin
        rd_idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end

      if (cmd_i.exec && (op_q == tstt_pkg::OP_TICK)) begin
        ms_q        <= ms_q + CW'(1);
        tenth_adv_q <= tenth_wrap;
        sec_adv_q   <= sec_wrap;
        if (tenth_wrap) begin
          pre100_q <= '0;
          tenth_q  <= tenth_q + CW'(1);
        end else begin
          pre100_q <= pre100_q + tstt_pkg::TENTH_PRE_W'(1);
        end
        if (sec_wrap) begin
          pre1000_q <= '0;
          sec_q     <= sec_q + CW'(1);
        end else begin
          pre1000_q <= pre1000_q + tstt_pkg::SEC_PRE_W'(1);
        end
      end

      if (op_do) begin
        case (op_q)
          tstt_pkg::OP_START: begin
            running_q[op_idx] <= 1'b1;
            expired_q[op_idx] <= 1'b0;
          end
          tstt_pkg::OP_STOP: begin
            running_q[op_idx] <= 1'b0;
            expired_q[op_idx] <= 1'b0;
          end
          tstt_pkg::OP_RESTART, tstt_pkg::OP_READ_CLEAR, tstt_pkg::OP_CLEAR: begin
            expired_q[op_idx] <= 1'b0;
          end
          tstt_pkg::OP_FORCE: begin
            expired_q[op_idx] <= 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (hit) begin
        expired_q[eval_idx_q] <= 1'b1;
      end
    end
  end

  assign accepted_o   = acc_q;
  assign flag_value_o = flag_q;

endmodule

>>> rtl/core/tiered_soft_timer_table.sv
`timescale 1ns / 1ps
// Sequence: a table operation passes EXEC and RESP before out_valid_o rises; a
//   tick passes EXEC, a SCAN of every entry (one entry scanned per cycle), DRAIN and RESP.
// One word at a time: a new word is not taken until the last result is
//   loaded; the next word is taken in the cycle after the result is loaded.
// Reset: counters, prescalers, running and expired bits clear; period/origin RAM is not.

module tiered_soft_timer_table #(
  parameter int NUM_TIMERS = 32,  // table size, 3..255
  parameter int FAST_END   = 16,  // ids below this count ms
  parameter int MID_END    = 24   // ids below this count 100 ms, rest count s
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tstt_pkg::OP_W-1:0]   operation_i,
  input  logic [tstt_pkg::ID_W-1:0]   timer_id_i,
  input  logic [tstt_pkg::CNT_W-1:0]  period_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o,
  output logic                        flag_value_o
);

  // The controller sequences each word:
  //   IDLE  - take a word
  //   EXEC  - table op updates bits/RAM and forms the response; a tick
  //           advances the ms counter and the 100 ms / 1 s prescalers
  //   SCAN  - read period/origin for one entry per cycle; the entry read in
  //           the previous cycle is compared and, on expiry, re-based
  //   DRAIN - last entry's compare
  //   RESP  - park the response in the output register once it is free
  // The output register holds its word while stalled, independent of the
  // controller, so the block returns to IDLE as soon as the word is loaded.

  tstt_pkg::cmd_t cmd;
  tstt_pkg::sts_t sts;

  tstt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: tier counters, running/expired bit vectors, period and origin
  // RAMs, scan index and the elapsed-vs-period compare.
  tstt_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .FAST_END   (FAST_END),
    .MID_END    (MID_END)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (operation_i),
    .timer_id_i   (timer_id_i),
    .period_i     (period_i),
    .accepted_o   (accepted_o),
    .flag_value_o (flag_value_o)
  );

endmodule
